// ===== hdl/bba_pkg.sv =====
// shared types, op codes and defaults of the bitmap block allocator
package bba_pkg;

    // default geometry
    localparam int unsigned BLOCK_BYTES_DEF  = 4096;
    localparam int unsigned BITMAP_WORDS_DEF = 1024;

    // bitmap word layout
    localparam int unsigned WORD_BITS = 32;
    localparam logic [31:0] WORD_ONES = 32'hffff_ffff;

    // request codes
    typedef enum logic [1:0] {
        OP_ALLOC     = 2'd0,
        OP_FREE      = 2'd1,
        OP_MARK_USED = 2'd2,
        OP_MARK_FREE = 2'd3
    } t_op;

    // input request
    typedef struct packed {
        t_op         op;
        logic [31:0] address;
        logic [31:0] length;
    } t_in_req;

    // result of one request
    typedef struct packed {
        logic [31:0] block_address;
        logic        failed;
        logic [15:0] used_count;
    } t_out_rsp;

endpackage

// ===== hdl/bitmap_block_allocator_core.sv =====
// bitmap block allocator: used-block bitmap in one memory, scan, free and region marks
//
//   channel | direction | handshake               | payload
//   in      | request   | i_in_valid / o_in_stall | i_in  (op, address, length)
//   out     | result    | o_out_valid / i_out_stall | o_out (block_address, failed, used_count)
//
// one request at a time; a result waiting in the output register does not block the next request
// allocate: words are read in order from word 0 up to the first word with a clear bit, which is set
// free and region marks: accept, a setup state that clips the region, then a direct write per fully covered
//   word or a read and a write back per partly covered word, then the counter update and the result
// BLOCK_BYTES must be a power of two (the block does not enforce it); block indexes and addresses are plain shifts
// after reset a clearing pass writes every word to all ones, stall held high
// a stalled result stays in the output register until taken; a later result waits in S_DONE until then
module bitmap_block_allocator_core #(
    parameter int unsigned BLOCK_BYTES  = bba_pkg::BLOCK_BYTES_DEF,
    parameter int unsigned BITMAP_WORDS = bba_pkg::BITMAP_WORDS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bba_pkg::t_in_req  i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bba_pkg::t_out_rsp o_out
);
    import bba_pkg::*;

    // derived widths and constants
    localparam int unsigned TOTAL_BLOCKS = BITMAP_WORDS * WORD_BITS;
    localparam int unsigned WA_W   = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int unsigned BLK_W  = $clog2(TOTAL_BLOCKS + 1);
    localparam int unsigned SH     = $clog2(BLOCK_BYTES);
    localparam logic [BLK_W-1:0] TOTAL_B   = BLK_W'(TOTAL_BLOCKS);
    localparam logic [31:0]      TOTAL_32  = 32'(TOTAL_BLOCKS);
    localparam logic [WA_W-1:0]  LAST_WORD = WA_W'(BITMAP_WORDS - 1);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b0_0000_0001,
        S_IDLE  = 9'b0_0000_0010,
        S_SETUP = 9'b0_0000_0100,
        S_SCAN  = 9'b0_0000_1000,
        S_AMUL  = 9'b0_0001_0000,
        S_WALK  = 9'b0_0010_0000,
        S_RMW   = 9'b0_0100_0000,
        S_FIN   = 9'b0_1000_0000,
        S_DONE  = 9'b1_0000_0000
    } t_state;

    // registers and next values
    t_state           r_state,    n_state;
    t_op              r_op,       n_op;
    logic [31:0]      r_aq,       n_aq;
    logic [31:0]      r_lq,       n_lq;
    logic [WA_W-1:0]  r_chk,      n_chk;
    logic [WA_W-1:0]  r_clr,      n_clr;
    logic [BLK_W-1:0] r_cur,      n_cur;
    logic [BLK_W-1:0] r_end,      n_end;
    logic [BLK_W-1:0] r_inside,   n_inside;
    logic             r_fill,     n_fill;
    logic             r_fail,     n_fail;
    logic [31:0]      r_idx,      n_idx;
    logic [31:0]      r_res_addr, n_res_addr;
    logic [BLK_W-1:0] r_used,     n_used;
    t_out_rsp         r_out,      n_out;
    logic             r_out_vld,  n_out_vld;

    // bitmap memory and its port
    logic [31:0]     r_mem [BITMAP_WORDS];
    logic [31:0]     r_mem_q;
    logic            mem_re;
    logic [WA_W-1:0] mem_ra;
    logic            mem_we;
    logic [WA_W-1:0] mem_wa;
    logic [31:0]     mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_ra];
        end
    end

    // region bounds from the block indexes
    logic [31:0]      blocks;
    logic             in_range;
    logic [BLK_W-1:0] room;
    logic             fits;
    logic [BLK_W-1:0] clip_blocks;
    always_comb begin
        blocks      = (r_op == OP_FREE) ? 32'd1 : r_lq;
        in_range    = (r_aq < TOTAL_32);
        room        = TOTAL_B - r_aq[BLK_W-1:0];
        fits        = (blocks <= 32'(room));
        clip_blocks = in_range ? (fits ? blocks[BLK_W-1:0] : room) : '0;
    end

    // bit mask of the current word covered by the region
    logic [31:0]      walk_mask;
    logic [BLK_W-1:0] walk_next;
    always_comb begin
        walk_mask = WORD_ONES << r_cur[4:0];
        if (r_end[BLK_W-1:5] == r_cur[BLK_W-1:5]) begin
            walk_mask = walk_mask & ~(WORD_ONES << r_end[4:0]);
        end
        walk_next = {r_cur[BLK_W-1:5] + 1'b1, 5'b0};
    end

    // lowest clear bit of the word under scan
    logic [4:0] low_bit;
    always_comb begin
        low_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!r_mem_q[i]) begin
                low_bit = 5'(i);
            end
        end
    end

    // saturating counter moves
    logic [BLK_W-1:0] up_room;
    logic [BLK_W-1:0] cnt_up_one, cnt_up_in, cnt_down_in;
    always_comb begin
        up_room     = TOTAL_B - r_used;
        cnt_up_one  = (BLK_W'(1) >= up_room) ? TOTAL_B : r_used + BLK_W'(1);
        cnt_up_in   = (r_inside >= up_room) ? TOTAL_B : r_used + r_inside;
        cnt_down_in = (r_inside >= r_used) ? '0 : r_used - r_inside;
    end

    logic [31:0] used_ext;
    assign used_ext = 32'(r_used);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_aq       = r_aq;
        n_lq       = r_lq;
        n_chk      = r_chk;
        n_clr      = r_clr;
        n_cur      = r_cur;
        n_end      = r_end;
        n_inside   = r_inside;
        n_fill     = r_fill;
        n_fail     = r_fail;
        n_idx      = r_idx;
        n_res_addr = r_res_addr;
        n_used     = r_used;
        n_out      = r_out;
        n_out_vld  = r_out_vld && i_out_stall;
        mem_re     = 1'b0;
        mem_ra     = '0;
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = '0;

        case (r_state)
            // fill the bitmap with all ones after reset
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = WORD_ONES;
                n_clr  = r_clr + 1'b1;
                if (r_clr == LAST_WORD) begin
                    n_state = S_IDLE;
                end
            end
            // take a request, block indexes by shift
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op       = i_in.op;
                    n_aq       = i_in.address >> SH;
                    n_lq       = i_in.length >> SH;
                    n_fail     = 1'b0;
                    n_res_addr = '0;
                    n_fill     = (i_in.op == OP_MARK_USED);
                    if (i_in.op == OP_ALLOC) begin
                        mem_re  = 1'b1;
                        mem_ra  = '0;
                        n_chk   = '0;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_SETUP;
                    end
                end
            end
            // clip the region to the bitmap
            S_SETUP: begin
                n_inside = clip_blocks;
                n_cur    = r_aq[BLK_W-1:0];
                n_end    = r_aq[BLK_W-1:0] + clip_blocks;
                if (blocks == 32'd0) begin
                    n_state = S_DONE;
                end else begin
                    n_fail = !in_range || !fits;
                    if (clip_blocks == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            // one word per cycle, read data belongs to r_chk
            S_SCAN: begin
                if (r_mem_q != WORD_ONES) begin
                    if (r_chk == '0 && low_bit == '0) begin
                        n_fail  = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        mem_we  = 1'b1;
                        mem_wa  = r_chk;
                        mem_wd  = r_mem_q | (32'd1 << low_bit);
                        n_used  = cnt_up_one;
                        n_idx   = 32'({r_chk, low_bit});
                        n_state = S_AMUL;
                    end
                end else if (r_chk == LAST_WORD) begin
                    n_fail  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    mem_re = 1'b1;
                    mem_ra = r_chk + 1'b1;
                    n_chk  = r_chk + 1'b1;
                end
            end
            // byte address of the allocated block
            S_AMUL: begin
                n_res_addr = r_idx << SH;
                n_state    = S_DONE;
            end
            // whole words written directly, partial words read first
            S_WALK: begin
                if (walk_mask == WORD_ONES) begin
                    mem_we = 1'b1;
                    mem_wa = r_cur[5 +: WA_W];
                    mem_wd = r_fill ? WORD_ONES : '0;
                    if (walk_next >= r_end) begin
                        n_state = S_FIN;
                    end else begin
                        n_cur = walk_next;
                    end
                end else begin
                    mem_re  = 1'b1;
                    mem_ra  = r_cur[5 +: WA_W];
                    n_state = S_RMW;
                end
            end
            // write back the partial word
            S_RMW: begin
                mem_we = 1'b1;
                mem_wa = r_cur[5 +: WA_W];
                mem_wd = r_fill ? (r_mem_q | walk_mask) : (r_mem_q & ~walk_mask);
                if (walk_next >= r_end) begin
                    n_state = S_FIN;
                end else begin
                    n_cur   = walk_next;
                    n_state = S_WALK;
                end
            end
            // move the counter by the blocks inside the bitmap
            S_FIN: begin
                n_used  = r_fill ? cnt_up_in : cnt_down_in;
                n_state = S_DONE;
            end
            // hand over the result once the output register is free
            S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out.block_address = r_res_addr;
                    n_out.failed        = r_fail;
                    n_out.used_count    = used_ext[15:0];
                    n_out_vld           = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_used    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_used    <= n_used;
            r_out_vld <= n_out_vld;
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_aq       <= n_aq;
        r_lq       <= n_lq;
        r_chk      <= n_chk;
        r_cur      <= n_cur;
        r_end      <= n_end;
        r_inside   <= n_inside;
        r_fill     <= n_fill;
        r_fail     <= n_fail;
        r_idx      <= n_idx;
        r_res_addr <= n_res_addr;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

// ===== hdl/bba_checker.sv =====
// port-level checks of the bitmap block allocator and their binding
module bba_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input bba_pkg::t_in_req  i_in,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input bba_pkg::t_out_rsp o_out
);
    import bba_pkg::*;

    // reset empties the output and holds off requests during the clearing pass
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_stall))
        else $error("output valid or request ready right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled result changed");

    // the block is busy right after every accepted request
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while the previous one was still in work");

    // a failed request never reports a block address
    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.failed) |-> (o_out.block_address == 32'd0))
        else $error("failed result carries a block address");

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
